// ===== rtl/core/gldec_pkg.sv =====
// ----------------------------------------------------------------------------
// Glyph outline decoder package
// Shared types and constants for the glyph outline decoder: the record
// parser phases, result kinds and the event passed from parser to pen stage.
// ----------------------------------------------------------------------------
package gldec_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FIELD_W     = 31;
    localparam int DELTA_W     = 17;
    localparam int CNT_W       = 5;

    typedef enum logic [4:0] {
        PH_HDR,
        PH_TYPE,
        PH_STRAIGHT,
        PH_NBITS,
        PH_GENERAL,
        PH_VERT,
        PH_DX,
        PH_DY,
        PH_ONE,
        PH_CDX,
        PH_CDY,
        PH_ADX,
        PH_ADY,
        PH_FLAGS,
        PH_MBITS,
        PH_MX,
        PH_MY,
        PH_FILL0,
        PH_FILL1,
        PH_LSTYLE
    } phase_t;

    typedef enum logic [1:0] {
        KIND_SEGMENT = 2'd0,
        KIND_DONE    = 2'd1,
        KIND_ERROR   = 2'd2
    } kind_t;

    // Everything one byte leaves for the pen stage. Deltas and moves are raw
    // field bits; width is the field width used to sign-extend them.
    typedef struct packed {
        logic               seg;
        logic               curve;
        logic [CNT_W-1:0]   width;
        logic [DELTA_W-1:0] d1x;
        logic [DELTA_W-1:0] d1y;
        logic [DELTA_W-1:0] d2x;
        logic [DELTA_W-1:0] d2y;
        logic               mvx;
        logic               mvy;
        logic [FIELD_W-1:0] mx;
        logic [FIELD_W-1:0] my;
        logic               fin;
        kind_t              fin_kind;
    } ev_t;

endpackage

// ===== rtl/core/gldec_parser.sv =====
// ----------------------------------------------------------------------------
// Glyph outline record parser
// Walks the eight bits of one byte through the shape record fields and
// registers the resulting event: edge deltas, pen moves and glyph end.
// ----------------------------------------------------------------------------
module gldec_parser
    import gldec_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       stream_end,
    output ev_t        ev,
    output logic       ev_valid,
    input  logic       ev_take
);

    localparam logic [4:0] FLAG_MOVE  = 5'h01;
    localparam logic [4:0] FLAG_FILL0 = 5'h02;
    localparam logic [4:0] FLAG_FILL1 = 5'h04;
    localparam logic [4:0] FLAG_LINE  = 5'h08;
    localparam logic [4:0] FLAG_NEW   = 5'h10;

    typedef enum logic [1:0] {
        LM_GENERAL,
        LM_VERT,
        LM_HORIZ,
        LM_CURVE
    } lmode_t;

    typedef struct packed {
        phase_t             phase;
        logic [FIELD_W-1:0] fval;
        logic [CNT_W-1:0]   left;
        logic [3:0]         fill_w;
        logic [3:0]         line_w;
        logic [CNT_W-1:0]   dwidth;
        logic [4:0]         flags;
        lmode_t             lmode;
        logic [DELTA_W-1:0] hcx;
        logic [DELTA_W-1:0] hcy;
        logic [DELTA_W-1:0] hax;
    } pst_t;

    typedef struct packed {
        pst_t st;
        ev_t  ev;
        logic halted;
    } walk_t;

    function automatic pst_t idle_state();
        pst_t s;
        s       = '0;
        s.phase = PH_HDR;
        s.lmode = LM_GENERAL;
        return s;
    endfunction

    function automatic walk_t begin_field(walk_t w, phase_t p, logic [CNT_W-1:0] n);
        w.st.phase = p;
        w.st.left  = n;
        w.st.fval  = '0;
        return w;
    endfunction

    function automatic walk_t glyph_finish(walk_t w, kind_t k);
        w.ev.fin      = 1'b1;
        w.ev.fin_kind = k;
        w.st          = idle_state();
        w.halted      = 1'b1;
        return w;
    endfunction

    // Style fields of zero width take no bits, so they are passed over.
    function automatic walk_t style_stage(walk_t w, logic [2:0] stage);
        logic [4:0] f;
        f = w.st.flags;
        if (stage == 3'd0 && (f & FLAG_MOVE) != 5'd0) begin
            return begin_field(w, PH_MBITS, 5'd5);
        end
        if (stage <= 3'd1 && (f & FLAG_FILL0) != 5'd0 && w.st.fill_w != 4'd0) begin
            return begin_field(w, PH_FILL0, {1'b0, w.st.fill_w});
        end
        if (stage <= 3'd2 && (f & FLAG_FILL1) != 5'd0 && w.st.fill_w != 4'd0) begin
            return begin_field(w, PH_FILL1, {1'b0, w.st.fill_w});
        end
        if (stage <= 3'd3 && (f & FLAG_LINE) != 5'd0 && w.st.line_w != 4'd0) begin
            return begin_field(w, PH_LSTYLE, {1'b0, w.st.line_w});
        end
        if ((f & FLAG_NEW) != 5'd0) begin
            return glyph_finish(w, KIND_ERROR);
        end
        return begin_field(w, PH_TYPE, 5'd1);
    endfunction

    function automatic walk_t complete_field(walk_t w);
        logic [FIELD_W-1:0] v;
        v = w.st.fval;
        unique case (w.st.phase)
            PH_HDR: begin
                w.st.fill_w = v[7:4];
                w.st.line_w = v[3:0];
                w = begin_field(w, PH_TYPE, 5'd1);
            end
            PH_TYPE: begin
                if (v[0]) begin
                    w = begin_field(w, PH_STRAIGHT, 5'd1);
                end
                else begin
                    w = begin_field(w, PH_FLAGS, 5'd5);
                end
            end
            PH_STRAIGHT: begin
                w.st.lmode = v[0] ? LM_GENERAL : LM_CURVE;
                w = begin_field(w, PH_NBITS, 5'd4);
            end
            PH_NBITS: begin
                w.st.dwidth = {1'b0, v[3:0]} + 5'd2;
                if (w.st.lmode == LM_CURVE) begin
                    w = begin_field(w, PH_CDX, w.st.dwidth);
                end
                else begin
                    w = begin_field(w, PH_GENERAL, 5'd1);
                end
            end
            PH_GENERAL: begin
                if (v[0]) begin
                    w.st.lmode = LM_GENERAL;
                    w = begin_field(w, PH_DX, w.st.dwidth);
                end
                else begin
                    w = begin_field(w, PH_VERT, 5'd1);
                end
            end
            PH_VERT: begin
                w.st.lmode = v[0] ? LM_VERT : LM_HORIZ;
                w = begin_field(w, PH_ONE, w.st.dwidth);
            end
            PH_DX: begin
                w.st.hcx = v[DELTA_W-1:0];
                w = begin_field(w, PH_DY, w.st.dwidth);
            end
            PH_DY: begin
                w.ev.seg   = 1'b1;
                w.ev.curve = 1'b0;
                w.ev.width = w.st.dwidth;
                w.ev.d1x   = w.st.hcx;
                w.ev.d1y   = v[DELTA_W-1:0];
                w.ev.d2x   = '0;
                w.ev.d2y   = '0;
                w = begin_field(w, PH_TYPE, 5'd1);
            end
            PH_ONE: begin
                w.ev.seg   = 1'b1;
                w.ev.curve = 1'b0;
                w.ev.width = w.st.dwidth;
                w.ev.d2x   = '0;
                w.ev.d2y   = '0;
                if (w.st.lmode == LM_VERT) begin
                    w.ev.d1x = '0;
                    w.ev.d1y = v[DELTA_W-1:0];
                end
                else begin
                    w.ev.d1x = v[DELTA_W-1:0];
                    w.ev.d1y = '0;
                end
                w = begin_field(w, PH_TYPE, 5'd1);
            end
            PH_CDX: begin
                w.st.hcx = v[DELTA_W-1:0];
                w = begin_field(w, PH_CDY, w.st.dwidth);
            end
            PH_CDY: begin
                w.st.hcy = v[DELTA_W-1:0];
                w = begin_field(w, PH_ADX, w.st.dwidth);
            end
            PH_ADX: begin
                w.st.hax = v[DELTA_W-1:0];
                w = begin_field(w, PH_ADY, w.st.dwidth);
            end
            PH_ADY: begin
                w.ev.seg   = 1'b1;
                w.ev.curve = 1'b1;
                w.ev.width = w.st.dwidth;
                w.ev.d1x   = w.st.hcx;
                w.ev.d1y   = w.st.hcy;
                w.ev.d2x   = w.st.hax;
                w.ev.d2y   = v[DELTA_W-1:0];
                w = begin_field(w, PH_TYPE, 5'd1);
            end
            PH_FLAGS: begin
                if (v[4:0] == 5'd0) begin
                    w = glyph_finish(w, KIND_DONE);
                end
                else begin
                    w.st.flags = v[4:0];
                    w = style_stage(w, 3'd0);
                end
            end
            PH_MBITS: begin
                w.st.dwidth = v[4:0];
                if (v[4:0] == 5'd0) begin
                    w.ev.mvx   = 1'b1;
                    w.ev.mvy   = 1'b1;
                    w.ev.mx    = '0;
                    w.ev.my    = '0;
                    w.ev.width = '0;
                    w = style_stage(w, 3'd1);
                end
                else begin
                    w = begin_field(w, PH_MX, v[4:0]);
                end
            end
            PH_MX: begin
                w.ev.mvx   = 1'b1;
                w.ev.mx    = v;
                w.ev.width = w.st.dwidth;
                w = begin_field(w, PH_MY, w.st.dwidth);
            end
            PH_MY: begin
                w.ev.mvy   = 1'b1;
                w.ev.my    = v;
                w.ev.width = w.st.dwidth;
                w = style_stage(w, 3'd1);
            end
            PH_FILL0: begin
                w = style_stage(w, 3'd2);
            end
            PH_FILL1: begin
                w = style_stage(w, 3'd3);
            end
            PH_LSTYLE: begin
                w = style_stage(w, 3'd4);
            end
            default: begin
                w = glyph_finish(w, KIND_ERROR);
            end
        endcase
        return w;
    endfunction

    function automatic walk_t take_bit(walk_t w, logic b);
        if (w.halted) begin
            return w;
        end
        if (w.st.phase == PH_HDR && w.st.left == 5'd0) begin
            w.st.left = 5'd8;
            w.st.fval = '0;
        end
        w.st.fval = {w.st.fval[FIELD_W-2:0], b};
        w.st.left = w.st.left - 5'd1;
        if (w.st.left == 5'd0) begin
            w = complete_field(w);
        end
        return w;
    endfunction

    pst_t  pst_reg;
    pst_t  pst_next;
    ev_t   ev_reg;
    logic  ev_valid_reg;
    logic  ev_valid_next;
    logic  accept;
    walk_t walk;

    assign in_ready = !ev_valid_reg || ev_take;
    assign accept   = in_valid && in_ready;
    assign ev       = ev_reg;
    assign ev_valid = ev_valid_reg;

    always_comb
    begin
        walk.st     = pst_reg;
        walk.ev     = '0;
        walk.halted = 1'b0;
        for (int i = 7; i >= 0; i--)
        begin
            walk = take_bit(walk, data_byte[3'(i)]);
        end
        if (!walk.halted && stream_end &&
            !(walk.st.phase == PH_HDR && walk.st.left == 5'd0))
        begin
            walk = glyph_finish(walk, KIND_ERROR);
        end
    end

    always_comb
    begin
        pst_next      = pst_reg;
        ev_valid_next = ev_valid_reg;
        if (accept)
        begin
            pst_next      = walk.st;
            ev_valid_next = 1'b1;
        end
        else if (ev_take)
        begin
            ev_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pst_reg      <= idle_state();
            ev_valid_reg <= 1'b0;
        end
        else
        begin
            pst_reg      <= pst_next;
            ev_valid_reg <= ev_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ev_reg <= walk.ev;
        end
    end

endmodule

// ===== rtl/core/glyph_outline_decoder.sv =====
// ----------------------------------------------------------------------------
// Glyph outline decoder
// Decodes a byte stream of vector glyph shape records into line and
// quadratic curve segments with absolute pen coordinates.
// ----------------------------------------------------------------------------
// One byte is taken per transfer and every cycle can take a byte while the
// parser's event register is empty or being taken; the parser walks all
// eight bits of a byte combinationally into its event register, and the pen
// stage adds the deltas and registers the result. A byte gives zero, one or
// two results; the output register hands out one result per transfer, so a
// byte ending a segment and the glyph holds input while the second waits.
module glyph_outline_decoder
    import gldec_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // data_byte
    input  logic         s_tlast,   // stream_end
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [191:0] m_tdata,   // from_x, from_y, ctrl_x, ctrl_y, end_x, end_y
    output logic [2:0]   m_tuser,   // kind, is_curve
    output logic         m_tlast    // last_of_run
);

    typedef struct packed {
        kind_t       kind;
        logic [31:0] from_x;
        logic [31:0] from_y;
        logic [31:0] ctrl_x;
        logic [31:0] ctrl_y;
        logic [31:0] end_x;
        logic [31:0] end_y;
        logic        is_curve;
        logic        last;
    } res_t;

    function automatic logic [31:0] sext_field(logic [FIELD_W-1:0] v, logic [CNT_W-1:0] n);
        logic              sign;
        logic [31:0]       r;
        logic [CNT_W-1:0]  top_i;
        if (n == '0) begin
            return '0;
        end
        top_i = n - 5'd1;
        sign  = v[top_i];
        for (int i = 0; i < FIELD_W; i++) begin
            r[i] = (i < n) ? v[i] : sign;
        end
        r[31] = sign;
        return r;
    endfunction

    function automatic logic [31:0] wrap_coord(logic [31:0] v);
        logic [31:0] r;
        for (int i = 0; i < 32; i++) begin
            r[i] = (i < COORD_WIDTH) ? v[i] : v[COORD_WIDTH-1];
        end
        return r;
    endfunction

    function automatic res_t finish_result(kind_t k);
        res_t r;
        r      = '0;
        r.kind = k;
        r.last = 1'b1;
        return r;
    endfunction

    ev_t         ev;
    logic        ev_valid;
    logic        ev_take;
    logic        ev_none;
    logic        out_free;

    logic [31:0] pen_x_reg;
    logic [31:0] pen_x_next;
    logic [31:0] pen_y_reg;
    logic [31:0] pen_y_next;
    res_t        out_reg;
    res_t        out_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        pend_valid_reg;
    logic        pend_valid_next;
    kind_t       pend_kind_reg;
    kind_t       pend_kind_next;

    logic [31:0] d1x_e;
    logic [31:0] d1y_e;
    logic [31:0] d2x_e;
    logic [31:0] d2y_e;
    logic [31:0] ctrl_x;
    logic [31:0] ctrl_y;
    logic [31:0] seg_end_x;
    logic [31:0] seg_end_y;
    logic [31:0] mov_x;
    logic [31:0] mov_y;
    res_t        seg_res;

    gldec_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .data_byte  (s_tdata),
        .stream_end (s_tlast),
        .ev         (ev),
        .ev_valid   (ev_valid),
        .ev_take    (ev_take)
    );

    assign ev_none  = !ev.seg && !ev.fin;
    assign out_free = !out_valid_reg || (m_tready && !pend_valid_reg);
    assign ev_take  = ev_valid && (ev_none || out_free);

    assign d1x_e     = sext_field({{(FIELD_W-DELTA_W){1'b0}}, ev.d1x}, ev.width);
    assign d1y_e     = sext_field({{(FIELD_W-DELTA_W){1'b0}}, ev.d1y}, ev.width);
    assign d2x_e     = sext_field({{(FIELD_W-DELTA_W){1'b0}}, ev.d2x}, ev.width);
    assign d2y_e     = sext_field({{(FIELD_W-DELTA_W){1'b0}}, ev.d2y}, ev.width);
    assign ctrl_x    = wrap_coord(pen_x_reg + d1x_e);
    assign ctrl_y    = wrap_coord(pen_y_reg + d1y_e);
    assign seg_end_x = wrap_coord(pen_x_reg + d1x_e + d2x_e);
    assign seg_end_y = wrap_coord(pen_y_reg + d1y_e + d2y_e);
    assign mov_x     = wrap_coord(sext_field(ev.mx, ev.width));
    assign mov_y     = wrap_coord(sext_field(ev.my, ev.width));

    always_comb
    begin
        seg_res          = '0;
        seg_res.kind     = KIND_SEGMENT;
        seg_res.from_x   = pen_x_reg;
        seg_res.from_y   = pen_y_reg;
        seg_res.ctrl_x   = ev.curve ? ctrl_x : '0;
        seg_res.ctrl_y   = ev.curve ? ctrl_y : '0;
        seg_res.end_x    = seg_end_x;
        seg_res.end_y    = seg_end_y;
        seg_res.is_curve = ev.curve;
        seg_res.last     = !ev.fin;
    end

    always_comb
    begin
        pen_x_next = pen_x_reg;
        pen_y_next = pen_y_reg;
        if (ev_take)
        begin
            priority if (ev.fin)
            begin
                pen_x_next = '0;
                pen_y_next = '0;
            end
            else if (ev.seg)
            begin
                pen_x_next = seg_end_x;
                pen_y_next = seg_end_y;
            end
            else
            begin
                if (ev.mvx)
                begin
                    pen_x_next = mov_x;
                end
                if (ev.mvy)
                begin
                    pen_y_next = mov_y;
                end
            end
        end
    end

    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        pend_valid_next = pend_valid_reg;
        pend_kind_next  = pend_kind_reg;
        priority if (ev_take && !ev_none)
        begin
            out_valid_next = 1'b1;
            if (ev.seg)
            begin
                out_next        = seg_res;
                pend_valid_next = ev.fin;
                pend_kind_next  = ev.fin_kind;
            end
            else
            begin
                out_next        = finish_result(ev.fin_kind);
                pend_valid_next = 1'b0;
            end
        end
        else if (out_valid_reg && m_tready)
        begin
            if (pend_valid_reg)
            begin
                out_next        = finish_result(pend_kind_reg);
                pend_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pen_x_reg      <= '0;
            pen_y_reg      <= '0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            pen_x_reg      <= pen_x_next;
            pen_y_reg      <= pen_y_next;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg       <= out_next;
        pend_kind_reg <= pend_kind_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.end_y, out_reg.end_x, out_reg.ctrl_y, out_reg.ctrl_x,
                       out_reg.from_y, out_reg.from_x};
    assign m_tuser  = {out_reg.is_curve, out_reg.kind};
    assign m_tlast  = out_reg.last;

`ifndef SYNTHESIS
    a_pend_has_out: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> out_valid_reg)
        else $error("A second result is waiting without a first one on the output.");

    a_pend_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (pend_kind_reg == KIND_DONE || pend_kind_reg == KIND_ERROR))
        else $error("A waiting second result is not a glyph end.");

    a_not_last_seg: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_reg.last |-> pend_valid_reg && out_reg.kind == KIND_SEGMENT)
        else $error("A result that is not last has no follower.");

    a_end_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.kind != KIND_SEGMENT |->
            out_reg.last && !out_reg.is_curve && out_reg.end_x == '0 && out_reg.end_y == '0)
        else $error("A glyph end result carries segment data.");
`endif

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// Glyph outline decoder testbench
// Feeds byte streams of glyph outlines, mostly well-formed glyphs with random
// edges and style changes plus truncated glyphs, new-style errors and noise,
// and checks every result transfer against a bit-exact outline predictor.
// ----------------------------------------------------------------------------
module tb_top;
    import gldec_pkg::*;

    localparam int LM_GENERAL = 0;
    localparam int LM_VERT    = 1;
    localparam int LM_HORIZ   = 2;
    localparam int LM_CURVE   = 3;

    localparam logic [4:0] FL_MOVE      = 5'h01;
    localparam logic [4:0] FL_FILL0     = 5'h02;
    localparam logic [4:0] FL_FILL1     = 5'h04;
    localparam logic [4:0] FL_LINE      = 5'h08;
    localparam logic [4:0] FL_NEWSTYLES = 5'h10;

    localparam int END_DONE   = 0;
    localparam int END_LAST   = 1;
    localparam int END_STYLES = 2;
    localparam int END_TRUNC  = 3;

    localparam int STALL_LIMIT = 2000;
    localparam int MAX_PRINTED = 40;

    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       hold;
    } stream_item_t;

    typedef struct {
        kind_t       kind;
        logic [31:0] fx;
        logic [31:0] fy;
        logic [31:0] cx;
        logic [31:0] cy;
        logic [31:0] ex;
        logic [31:0] ey;
        logic        curve;
        logic        last;
    } outline_result_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = 8'h00;
    logic         s_tlast = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [191:0] m_tdata;
    logic [2:0]   m_tuser;
    logic         m_tlast;

    stream_item_t    byte_q[$];
    stream_item_t    next_item;
    outline_result_t expected_q[$];
    outline_result_t byte_results[$];
    outline_result_t want;
    bit              gen_bits[$];

    int gen_fill_w;
    int gen_line_w;
    int bytes_total;
    int bytes_sent;
    int results_seen;
    int errors;
    int stall_cycles;

    phase_t      dec_phase;
    logic [31:0] fld_val;
    int          fld_left;
    logic [3:0]  fill_w;
    logic [3:0]  line_w;
    int          delta_w;
    logic [4:0]  rec_flags;
    logic [31:0] pen_x;
    logic [31:0] pen_y;
    logic [31:0] ctl_x;
    logic [31:0] ctl_y;
    logic [31:0] anchor_dx;
    int          seg_mode;
    bit          glyph_halted;

    glyph_outline_decoder u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Outline predictor
    // ------------------------------------------------------------------------
    function automatic logic [31:0] sign_ext(logic [31:0] v, int n);
        if (n == 0)
            return 32'd0;
        if (n > 31)
            return v;
        if (v[n-1])
            return v | ~((32'd1 << n) - 32'd1);
        return v;
    endfunction

    function automatic void clear_glyph();
        dec_phase = PH_HDR;
        fld_val = '0;
        fld_left = 0;
        fill_w = '0;
        line_w = '0;
        delta_w = 0;
        rec_flags = '0;
        pen_x = '0;
        pen_y = '0;
        ctl_x = '0;
        ctl_y = '0;
        anchor_dx = '0;
        seg_mode = LM_GENERAL;
    endfunction

    function automatic void begin_field(phase_t p, int n);
        dec_phase = p;
        fld_left = n & 31;
        fld_val = '0;
    endfunction

    function automatic void add_result(kind_t k, logic [31:0] fx, logic [31:0] fy,
                                       logic [31:0] cx, logic [31:0] cy,
                                       logic [31:0] ex, logic [31:0] ey, logic curve);
        outline_result_t r;
        if (byte_results.size() >= 2)
            return;
        r.kind = k;
        r.fx = fx;
        r.fy = fy;
        r.cx = cx;
        r.cy = cy;
        r.ex = ex;
        r.ey = ey;
        r.curve = curve;
        r.last = 1'b0;
        byte_results.insert(byte_results.size(), r);
    endfunction

    function automatic void end_glyph(kind_t k);
        add_result(k, '0, '0, '0, '0, '0, '0, 1'b0);
        clear_glyph();
        glyph_halted = 1'b1;
    endfunction

    function automatic void style_step(int stage);
        if (stage <= 0 && (rec_flags & FL_MOVE) != 0)
            begin_field(PH_MBITS, 5);
        else if (stage <= 1 && (rec_flags & FL_FILL0) != 0)
            begin_field(PH_FILL0, int'(fill_w));
        else if (stage <= 2 && (rec_flags & FL_FILL1) != 0)
            begin_field(PH_FILL1, int'(fill_w));
        else if (stage <= 3 && (rec_flags & FL_LINE) != 0)
            begin_field(PH_LSTYLE, int'(line_w));
        else if ((rec_flags & FL_NEWSTYLES) != 0)
            end_glyph(KIND_ERROR);
        else
            begin_field(PH_TYPE, 1);
    endfunction

    function automatic void draw_line(logic [31:0] dx, logic [31:0] dy);
        logic [31:0] ex;
        logic [31:0] ey;
        ex = pen_x + dx;
        ey = pen_y + dy;
        add_result(KIND_SEGMENT, pen_x, pen_y, '0, '0, ex, ey, 1'b0);
        pen_x = ex;
        pen_y = ey;
        begin_field(PH_TYPE, 1);
    endfunction

    function automatic void finish_field();
        logic [31:0] v;
        logic [31:0] d;
        logic [31:0] ex;
        logic [31:0] ey;
        v = fld_val;
        d = sign_ext(v, delta_w);
        case (dec_phase)
            PH_HDR:
            begin
                fill_w = v[7:4];
                line_w = v[3:0];
                begin_field(PH_TYPE, 1);
            end
            PH_TYPE:
                if (v != 0)
                    begin_field(PH_STRAIGHT, 1);
                else
                    begin_field(PH_FLAGS, 5);
            PH_STRAIGHT:
            begin
                seg_mode = (v != 0) ? LM_GENERAL : LM_CURVE;
                begin_field(PH_NBITS, 4);
            end
            PH_NBITS:
            begin
                delta_w = int'(v[3:0]) + 2;
                if (seg_mode == LM_CURVE)
                    begin_field(PH_CDX, delta_w);
                else
                    begin_field(PH_GENERAL, 1);
            end
            PH_GENERAL:
                if (v != 0)
                begin
                    seg_mode = LM_GENERAL;
                    begin_field(PH_DX, delta_w);
                end
                else
                    begin_field(PH_VERT, 1);
            PH_VERT:
            begin
                seg_mode = (v != 0) ? LM_VERT : LM_HORIZ;
                begin_field(PH_ONE, delta_w);
            end
            PH_DX:
            begin
                ctl_x = d;
                begin_field(PH_DY, delta_w);
            end
            PH_DY:
                draw_line(ctl_x, d);
            PH_ONE:
                if (seg_mode == LM_VERT)
                    draw_line('0, d);
                else
                    draw_line(d, '0);
            PH_CDX:
            begin
                ctl_x = pen_x + d;
                begin_field(PH_CDY, delta_w);
            end
            PH_CDY:
            begin
                ctl_y = pen_y + d;
                begin_field(PH_ADX, delta_w);
            end
            PH_ADX:
            begin
                anchor_dx = d;
                begin_field(PH_ADY, delta_w);
            end
            PH_ADY:
            begin
                ex = ctl_x + anchor_dx;
                ey = ctl_y + d;
                add_result(KIND_SEGMENT, pen_x, pen_y, ctl_x, ctl_y, ex, ey, 1'b1);
                pen_x = ex;
                pen_y = ey;
                begin_field(PH_TYPE, 1);
            end
            PH_FLAGS:
                if (v == 0)
                    end_glyph(KIND_DONE);
                else
                begin
                    rec_flags = v[4:0];
                    style_step(0);
                end
            PH_MBITS:
            begin
                delta_w = int'(v[4:0]);
                begin_field(PH_MX, delta_w);
            end
            PH_MX:
            begin
                pen_x = d;
                begin_field(PH_MY, delta_w);
            end
            PH_MY:
            begin
                pen_y = d;
                style_step(1);
            end
            PH_FILL0:
                style_step(2);
            PH_FILL1:
                style_step(3);
            PH_LSTYLE:
                style_step(4);
            default:
                end_glyph(KIND_ERROR);
        endcase
    endfunction

    function automatic void take_bit(logic b);
        if (dec_phase == PH_HDR && fld_left == 0)
        begin
            fld_left = 8;
            fld_val = '0;
        end
        fld_val = {fld_val[30:0], b};
        fld_left--;
        if (fld_left != 0)
            return;
        finish_field();
        while (!glyph_halted && fld_left == 0 && dec_phase != PH_HDR)
            finish_field();
    endfunction

    function automatic void decode_byte(logic [7:0] data, logic last);
        int i;
        byte_results.delete();
        glyph_halted = 1'b0;
        for (i = 7; i >= 0; i--)
            if (!glyph_halted)
                take_bit(data[i]);
        if (!glyph_halted && last && !(dec_phase == PH_HDR && fld_left == 0))
            end_glyph(KIND_ERROR);
        glyph_halted = 1'b0;
        if (byte_results.size() != 0)
            byte_results[byte_results.size()-1].last = 1'b1;
        foreach (byte_results[j])
            expected_q.insert(expected_q.size(), byte_results[j]);
    endfunction

    // ------------------------------------------------------------------------
    // Outline stream generator
    // ------------------------------------------------------------------------
    function automatic logic [31:0] rand_field(int n);
        logic [31:0] mask;
        logic [31:0] v;
        if (n == 0)
            return 32'd0;
        mask = (n >= 32) ? 32'hFFFF_FFFF : ((32'd1 << n) - 32'd1);
        case ($urandom_range(0, 5))
            0: v = 32'd1 << (n - 1);
            1: v = (32'd1 << (n - 1)) - 32'd1;
            2: v = mask;
            3: v = 32'd0;
            default: v = $urandom;
        endcase
        return v & mask;
    endfunction

    function automatic void put_bits(logic [31:0] v, int n);
        int i;
        for (i = n - 1; i >= 0; i--)
            gen_bits.insert(gen_bits.size(), v[i]);
    endfunction

    function automatic void put_header();
        put_bits(gen_fill_w, 4);
        put_bits(gen_line_w, 4);
    endfunction

    function automatic void put_end();
        put_bits(0, 1);
        put_bits(0, 5);
    endfunction

    function automatic void put_edge(int mode, int nb);
        int n;
        n = nb + 2;
        put_bits(1, 1);
        if (mode == LM_CURVE)
        begin
            put_bits(0, 1);
            put_bits(nb, 4);
            repeat (4)
                put_bits(rand_field(n), n);
        end
        else
        begin
            put_bits(1, 1);
            put_bits(nb, 4);
            if (mode == LM_GENERAL)
            begin
                put_bits(1, 1);
                put_bits(rand_field(n), n);
                put_bits(rand_field(n), n);
            end
            else
            begin
                put_bits(0, 1);
                put_bits(32'(mode == LM_VERT), 1);
                put_bits(rand_field(n), n);
            end
        end
    endfunction

    function automatic void put_style(logic [4:0] flags, int mbits);
        put_bits(0, 1);
        put_bits(32'(flags), 5);
        if ((flags & FL_MOVE) != 0)
        begin
            put_bits(mbits, 5);
            put_bits(rand_field(mbits), mbits);
            put_bits(rand_field(mbits), mbits);
        end
        if ((flags & FL_FILL0) != 0)
            put_bits(rand_field(gen_fill_w), gen_fill_w);
        if ((flags & FL_FILL1) != 0)
            put_bits(rand_field(gen_fill_w), gen_fill_w);
        if ((flags & FL_LINE) != 0)
            put_bits(rand_field(gen_line_w), gen_line_w);
    endfunction

    function automatic void queue_glyph(int ending, bit hold);
        int nbytes;
        int cut;
        int i;
        int j;
        stream_item_t it;
        while (gen_bits.size() % 8 != 0)
            gen_bits.insert(gen_bits.size(), 1'($urandom_range(0, 1)));
        nbytes = gen_bits.size() / 8;
        cut = nbytes - 1;
        if (ending == END_TRUNC)
            cut = $urandom_range(0, nbytes - 2);
        for (i = 0; i <= cut; i++)
        begin
            for (j = 0; j < 8; j++)
                it.data[7-j] = gen_bits[8*i+j];
            it.last = (i == cut) && (ending == END_TRUNC || ending == END_LAST);
            it.hold = hold && (i == 0);
            byte_q.insert(byte_q.size(), it);
        end
        gen_bits.delete();
    endfunction

    function automatic int rand_delta_bits();
        return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 4);
    endfunction

    function automatic int rand_move_bits();
        return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 8);
    endfunction

    function automatic void random_glyph(bit hold);
        int ending;
        int r;
        int nrec;
        int i;
        r = $urandom_range(0, 99);
        if (r < 12)
            ending = END_STYLES;
        else if (r < 28)
            ending = END_TRUNC;
        else if (r < 50)
            ending = END_LAST;
        else
            ending = END_DONE;
        gen_fill_w = $urandom_range(0, 15);
        gen_line_w = $urandom_range(0, 15);
        put_header();
        nrec = $urandom_range(0, 5);
        for (i = 0; i < nrec; i++)
        begin
            r = $urandom_range(0, 4);
            if (r == 4)
                put_style(5'($urandom_range(1, 15)), rand_move_bits());
            else
                put_edge(r, rand_delta_bits());
        end
        if (ending == END_STYLES)
            put_style(FL_NEWSTYLES | 5'($urandom_range(0, 15)), rand_move_bits());
        else
            put_end();
        queue_glyph(ending, hold);
    endfunction

    function automatic void random_noise();
        int n;
        int i;
        stream_item_t it;
        n = $urandom_range(1, 6);
        for (i = 0; i < n; i++)
        begin
            it.data = 8'($urandom_range(0, 255));
            it.last = (i == n - 1);
            it.hold = 1'b0;
            byte_q.insert(byte_q.size(), it);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Driver and monitor
    // ------------------------------------------------------------------------
    function automatic int sender_idle_pct();
        if (bytes_sent < bytes_total / 3)
            return 19;
        if (bytes_sent < 2 * bytes_total / 3)
            return 64;
        return 0;
    endfunction

    function automatic int receiver_idle_pct();
        if (bytes_sent < bytes_total / 3)
            return 64;
        if (bytes_sent < 2 * bytes_total / 3)
            return 19;
        return 0;
    endfunction

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= MAX_PRINTED)
            $display("mismatch at result %0d: %s", results_seen, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] g,
                               input logic [31:0] w);
        if (g !== w)
            report_mismatch($sformatf("%s got %h expected %h", name, g, w));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= 8'h00;
            s_tlast <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                decode_byte(s_tdata, s_tlast);
                bytes_sent++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (byte_q.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct()
                    && !(byte_q[0].hold && expected_q.size() != 0))
                begin
                    next_item = byte_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= next_item.data;
                    s_tlast <= next_item.last;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (expected_q.size() == 0)
                    report_mismatch("result with no expectation pending");
                else
                begin
                    want = expected_q.pop_front();
                    check_field("kind", 32'(m_tuser[1:0]), 32'(want.kind));
                    check_field("from_x", m_tdata[31:0], want.fx);
                    check_field("from_y", m_tdata[63:32], want.fy);
                    check_field("ctrl_x", m_tdata[95:64], want.cx);
                    check_field("ctrl_y", m_tdata[127:96], want.cy);
                    check_field("end_x", m_tdata[159:128], want.ex);
                    check_field("end_y", m_tdata[191:160], want.ey);
                    check_field("is_curve", 32'(m_tuser[2]), 32'(want.curve));
                    check_field("last_of_run", 32'(m_tlast), 32'(want.last));
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
            m_tready <= ($urandom_range(0, 99) >= receiver_idle_pct());
        end
    end

    initial
    begin
        clear_glyph();
        glyph_halted = 1'b0;
        errors = 0;
        bytes_sent = 0;
        results_seen = 0;
        stall_cycles = 0;

        // Empty glyph: header and end record only.
        gen_fill_w = 0;
        gen_line_w = 0;
        put_header();
        put_end();
        queue_glyph(END_DONE, 1'b0);

        // Every edge kind, then a style change with a zero-width move.
        gen_fill_w = 1;
        gen_line_w = 1;
        put_header();
        put_edge(LM_CURVE, 0);
        put_edge(LM_HORIZ, 0);
        put_edge(LM_VERT, 0);
        put_edge(LM_GENERAL, 0);
        put_style(FL_MOVE | FL_FILL0 | FL_FILL1 | FL_LINE, 0);
        put_end();
        queue_glyph(END_DONE, 1'b0);

        // New styles flag ends the glyph with an error.
        gen_fill_w = 0;
        gen_line_w = 0;
        put_header();
        put_style(FL_NEWSTYLES, 0);
        queue_glyph(END_STYLES, 1'b0);

        // Stream ends right after the header.
        next_item.data = 8'h5A;
        next_item.last = 1'b1;
        next_item.hold = 1'b0;
        byte_q.insert(byte_q.size(), next_item);

        // Widest deltas, with the end record on the final byte of the stream.
        put_header();
        put_edge(LM_GENERAL, 15);
        put_end();
        queue_glyph(END_LAST, 1'b0);

        random_glyph(1'b1);
        while (byte_q.size() < 945)
        begin
            if ($urandom_range(0, 9) == 0)
                random_noise();
            else
                random_glyph($urandom_range(0, 49) == 0);
        end
        bytes_total = byte_q.size();

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (byte_q.size() != 0 || s_tvalid)
            @(posedge clk);
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
